@@ hw/rtl/arb_pkg.sv @@
// shared types, constants and codes for the ack retransmit buffer
`timescale 1ns / 1ps

package arb_pkg;

    // table geometry
    localparam int SLOTS  = 8;
    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_W = 3;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF = 2'd2;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
    localparam logic [7:0] MAX_RETRIES_RESET = 8'd3;
    localparam logic [7:0] BACKOFF_RESET = 8'd20;
    localparam logic [7:0] RETRY_TOP = 8'd255;

    // opcodes
    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_ACK = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    typedef enum logic [3:0] {
        EV_ADDED   = 4'd0,
        EV_DUP     = 4'd1,
        EV_FULL    = 4'd2,
        EV_INVALID = 4'd3,
        EV_ACKED   = 4'd4,
        EV_UNKNOWN = 4'd5,
        EV_RESEND  = 4'd6,
        EV_DROPPED = 4'd7,
        EV_DONE    = 4'd8
    } event_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_ADD_SCAN,
        ST_ADD_END,
        ST_ACK_SCAN,
        ST_ACK_MISS,
        ST_TICK_SCAN,
        ST_TICK_DONE,
        ST_INVALID
    } ctrl_state_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [15:0] dest_addr;
        logic [31:0] seq_num;
        logic [31:0] now_ms;
        logic [7:0]  pkt_handle;
    } in_item_t;

    typedef struct packed {
        logic [3:0]  event_res;
        logic [2:0]  slot;
        logic [15:0] out_dest;
        logic [31:0] out_seq;
        logic [7:0]  out_handle;
        logic [7:0]  retry_count;
        logic        last;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic   load;
        logic   idx_clear;
        logic   idx_step;
        logic   note_free;
        logic   wr_add;
        logic   clr_cur;
        logic   wr_resend;
        logic   emit;
        event_t ev;
    } arb_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] opcode;
        logic       dest_zero;
        logic       in_use;
        logic       dup_hit;
        logic       ack_hit;
        logic       drop_hit;
        logic       due_hit;
        logic       last_idx;
        logic       free_found;
        logic       out_room;
    } arb_status_t;

endpackage

@@ hw/rtl/arb_ctrl.sv @@
// controller state machine: sequences the slot scan of each operation
`timescale 1ns / 1ps

module arb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  arb_pkg::arb_status_t status,
    output arb_pkg::arb_cmd_t    cmd
);
    import arb_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.ev = EV_DONE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.idx_clear = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (status.opcode)
                    OP_ADD:  state_next = status.dest_zero ? ST_INVALID : ST_ADD_SCAN;
                    OP_ACK:  state_next = ST_ACK_SCAN;
                    OP_TICK: state_next = ST_TICK_SCAN;
                    default: state_next = ST_INVALID;
                endcase
            end
            ST_ADD_SCAN:
            begin
                if (status.dup_hit)
                begin
                    if (status.out_room)
                    begin
                        cmd.emit = 1'b1;
                        cmd.ev = EV_DUP;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.note_free = 1'b1;
                    if (status.last_idx)
                    begin
                        state_next = ST_ADD_END;
                    end
                    else
                    begin
                        cmd.idx_step = 1'b1;
                    end
                end
            end
            ST_ADD_END:
            begin
                if (status.out_room)
                begin
                    cmd.emit = 1'b1;
                    if (status.free_found)
                    begin
                        cmd.wr_add = 1'b1;
                        cmd.ev = EV_ADDED;
                    end
                    else
                    begin
                        cmd.ev = EV_FULL;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_ACK_SCAN:
            begin
                if (status.ack_hit)
                begin
                    if (status.out_room)
                    begin
                        cmd.emit = 1'b1;
                        cmd.ev = EV_ACKED;
                        cmd.clr_cur = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
                else if (status.last_idx)
                begin
                    state_next = ST_ACK_MISS;
                end
                else
                begin
                    cmd.idx_step = 1'b1;
                end
            end
            ST_ACK_MISS:
            begin
                if (status.out_room)
                begin
                    cmd.emit = 1'b1;
                    cmd.ev = EV_UNKNOWN;
                    state_next = ST_IDLE;
                end
            end
            ST_TICK_SCAN:
            begin
                // a slot that needs a result waits here for output room
                if (status.in_use && (status.drop_hit || status.due_hit) && !status.out_room)
                begin
                    state_next = ST_TICK_SCAN;
                end
                else
                begin
                    if (status.in_use && status.drop_hit)
                    begin
                        cmd.emit = 1'b1;
                        cmd.ev = EV_DROPPED;
                        cmd.clr_cur = 1'b1;
                    end
                    else if (status.in_use && status.due_hit)
                    begin
                        cmd.emit = 1'b1;
                        cmd.ev = EV_RESEND;
                        cmd.wr_resend = 1'b1;
                    end
                    if (status.last_idx)
                    begin
                        state_next = ST_TICK_DONE;
                    end
                    else
                    begin
                        cmd.idx_step = 1'b1;
                    end
                end
            end
            ST_TICK_DONE:
            begin
                if (status.out_room)
                begin
                    cmd.emit = 1'b1;
                    cmd.ev = EV_DONE;
                    state_next = ST_IDLE;
                end
            end
            ST_INVALID:
            begin
                if (status.out_room)
                begin
                    cmd.emit = 1'b1;
                    cmd.ev = EV_INVALID;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/arb_datapath.sv @@
// datapath: slot table, configuration, scan index and output register
`timescale 1ns / 1ps

module arb_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  arb_pkg::in_item_t             in_data,
    output arb_pkg::out_item_t            out_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    input  logic                          cfg_we,
    input  logic [arb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  arb_pkg::arb_cmd_t             cmd,
    output arb_pkg::arb_status_t          status
);
    import arb_pkg::*;

    // slot table
    logic [15:0] dest_reg [SLOTS];
    logic [31:0] seq_reg [SLOTS];
    logic [31:0] time_reg [SLOTS];
    logic [7:0]  retries_reg [SLOTS];
    logic [7:0]  handle_reg [SLOTS];

    logic [15:0] timeout_reg;
    logic [7:0]  max_retries_reg;
    logic [7:0]  backoff_reg;

    in_item_t         item_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    out_item_t        out_reg;
    out_item_t        out_next;
    logic             out_valid_reg;

    logic [15:0] cur_dest;
    logic [31:0] cur_seq;
    logic [31:0] cur_time;
    logic [7:0]  cur_retries;
    logic [7:0]  cur_handle;
    logic        cur_in_use;
    logic [31:0] elapsed;
    logic [15:0] backoff_prod;
    logic [31:0] resend_time;
    logic [7:0]  retries_inc;
    logic        out_room;

    // current slot under the scan
    assign cur_dest    = dest_reg[idx_reg];
    assign cur_seq     = seq_reg[idx_reg];
    assign cur_time    = time_reg[idx_reg];
    assign cur_retries = retries_reg[idx_reg];
    assign cur_handle  = handle_reg[idx_reg];
    assign cur_in_use  = (cur_dest != 16'd0);

    // timeout test and backoff timestamp
    assign elapsed      = item_reg.now_ms - cur_time;
    assign backoff_prod = 16'(cur_retries) * 16'(backoff_reg);
    assign resend_time  = item_reg.now_ms + {16'd0, backoff_prod};
    assign retries_inc  = (cur_retries == RETRY_TOP) ? cur_retries : cur_retries + 8'd1;
    assign out_room     = !out_valid_reg || !out_stall;

    // status back to the controller
    always_comb
    begin
        status.opcode     = item_reg.opcode;
        status.dest_zero  = (item_reg.dest_addr == 16'd0);
        status.in_use     = cur_in_use;
        status.dup_hit    = cur_in_use && (cur_dest == item_reg.dest_addr)
                            && (cur_seq == item_reg.seq_num);
        status.ack_hit    = cur_in_use && (cur_seq == item_reg.seq_num);
        status.drop_hit   = (cur_retries > max_retries_reg);
        status.due_hit    = (cur_time == 32'd0)
                            || ((item_reg.now_ms > cur_time)
                                && (elapsed > {16'd0, timeout_reg})
                                && (item_reg.now_ms > {16'd0, timeout_reg}));
        status.last_idx   = (idx_reg == IDX_W'(SLOTS - 1));
        status.free_found = free_found_reg;
        status.out_room   = out_room;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg     <= TIMEOUT_RESET;
            max_retries_reg <= MAX_RETRIES_RESET;
            backoff_reg     <= BACKOFF_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TIMEOUT:     timeout_reg <= cfg_data;
                CFG_MAX_RETRIES: max_retries_reg <= cfg_data[7:0];
                CFG_BACKOFF:     backoff_reg <= cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // item latch, scan index and first free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
        end
        else
        begin
            if (cmd.idx_clear)
            begin
                idx_reg        <= '0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (cmd.idx_step)
                begin
                    idx_reg <= idx_reg + IDX_W'(1);
                end
                if (cmd.note_free && !cur_in_use && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
    end

    // slot destinations: zero marks a free slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                dest_reg[i] <= 16'd0;
            end
        end
        else if (cmd.wr_add)
        begin
            dest_reg[free_idx_reg] <= item_reg.dest_addr;
        end
        else if (cmd.clr_cur)
        begin
            dest_reg[idx_reg] <= 16'd0;
        end
    end

    // slot contents
    always_ff @(posedge clk)
    begin
        if (cmd.wr_add)
        begin
            seq_reg[free_idx_reg]     <= item_reg.seq_num;
            time_reg[free_idx_reg]    <= item_reg.now_ms;
            retries_reg[free_idx_reg] <= 8'd0;
            handle_reg[free_idx_reg]  <= item_reg.pkt_handle;
        end
        else if (cmd.wr_resend)
        begin
            time_reg[idx_reg]    <= resend_time;
            retries_reg[idx_reg] <= retries_inc;
        end
    end

    // result payload by event
    always_comb
    begin
        out_next = '0;
        out_next.event_res = cmd.ev;
        out_next.last = (cmd.ev != EV_RESEND) && (cmd.ev != EV_DROPPED);
        case (cmd.ev)
            EV_ADDED:
            begin
                out_next.slot       = SLOT_W'(free_idx_reg);
                out_next.out_dest   = item_reg.dest_addr;
                out_next.out_seq    = item_reg.seq_num;
                out_next.out_handle = item_reg.pkt_handle;
            end
            EV_DUP, EV_ACKED, EV_DROPPED:
            begin
                out_next.slot        = SLOT_W'(idx_reg);
                out_next.out_dest    = cur_dest;
                out_next.out_seq     = cur_seq;
                out_next.out_handle  = cur_handle;
                out_next.retry_count = cur_retries;
            end
            EV_RESEND:
            begin
                out_next.slot        = SLOT_W'(idx_reg);
                out_next.out_dest    = cur_dest;
                out_next.out_seq     = cur_seq;
                out_next.out_handle  = cur_handle;
                out_next.retry_count = retries_inc;
            end
            EV_FULL, EV_INVALID:
            begin
                out_next.out_dest   = item_reg.dest_addr;
                out_next.out_seq    = item_reg.seq_num;
                out_next.out_handle = item_reg.pkt_handle;
            end
            EV_UNKNOWN:
            begin
                out_next.out_seq = item_reg.seq_num;
            end
            default:
            begin
                out_next.out_seq = 32'd0;
            end
        endcase
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data  = out_reg;
    assign out_valid = out_valid_reg;

endmodule

@@ hw/rtl/ack_retransmit_buffer_unit.sv @@
// top level of the ack retransmit buffer: controller and datapath
`timescale 1ns / 1ps
// sequence: an item is taken in idle, decoded in the dispatch state, then the table is walked one
// slot a cycle, unless a slot that needs a result waits for output room; add, ack miss and tick
// end in a final result state, an ack hit or duplicate ends early at the matching slot.
// throughput: one item at a time, set by the single shared slot read port of the scan.
// reset: all slots free, timeout 1000, retry limit 3, backoff step 20, output empty.

module ack_retransmit_buffer_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  arb_pkg::in_item_t             in_data,
    output logic                          out_valid,
    input  logic                          out_stall,
    output arb_pkg::out_item_t            out_data,
    input  logic                          cfg_we,
    input  logic [arb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import arb_pkg::*;

    arb_cmd_t    cmd;
    arb_status_t status;

    // sequencer
    arb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // table and result path
    arb_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ tb/sv/testbench.sv @@
// self-checking testbench for the ack retransmit buffer: directed and random traffic
`timescale 1ns / 1ps

module testbench;
    import arb_pkg::*;

    // the one opcode that the table does not decode
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // predicted slot table and register copies
    logic [15:0] tbl_dest    [SLOTS];
    logic [31:0] tbl_seq     [SLOTS];
    logic [31:0] tbl_time    [SLOTS];
    logic [7:0]  tbl_retries [SLOTS];
    logic [7:0]  tbl_handle  [SLOTS];
    logic [15:0] cur_timeout;
    logic [7:0]  cur_max_retries;
    logic [7:0]  cur_backoff;

    out_item_t   awaited_events[$];
    int          mismatch_count;
    int          results_seen;
    logic        idle_on;
    logic [31:0] wall_ms;

    ack_retransmit_buffer_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard limit on run length
    initial
    begin
        #10_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver back-pressure, changed on the falling edge
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= idle_on && ($urandom_range(99) < 29);
        end
    end

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 50)
            $display("error at %0t: result %0d: %s", $realtime, results_seen, msg);
    endtask

    task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
    endtask

    function automatic void push_event(event_t ev, logic [2:0] idx, logic [15:0] dest,
                                       logic [31:0] seq, logic [7:0] handle,
                                       logic [7:0] retries, logic fin);
        out_item_t e;
        e.event_res   = ev;
        e.slot        = idx;
        e.out_dest    = dest;
        e.out_seq     = seq;
        e.out_handle  = handle;
        e.retry_count = retries;
        e.last        = fin;
        awaited_events.push_back(e);
    endfunction

    function automatic void push_slot_event(event_t ev, int i, logic fin);
        push_event(ev, 3'(i), tbl_dest[i], tbl_seq[i], tbl_handle[i], tbl_retries[i], fin);
    endfunction

    function automatic void clear_entry(int i);
        tbl_dest[i]    = '0;
        tbl_seq[i]     = '0;
        tbl_time[i]    = '0;
        tbl_retries[i] = '0;
        tbl_handle[i]  = '0;
    endfunction

    // works out the events that one accepted item causes and updates the table
    function automatic void predict_buffer_events(in_item_t it);
        int          i;
        int          hit;
        logic [31:0] age;
        logic        due;
        hit = -1;
        case (it.opcode)
            OP_ADD:
            begin
                if (it.dest_addr == '0)
                    push_event(EV_INVALID, '0, it.dest_addr, it.seq_num, it.pkt_handle, '0, 1'b1);
                else
                begin
                    for (i = 0; i < SLOTS; i++)
                        if (hit < 0 && tbl_dest[i] != '0 && tbl_dest[i] == it.dest_addr
                            && tbl_seq[i] == it.seq_num)
                            hit = i;
                    if (hit >= 0)
                        push_slot_event(EV_DUP, hit, 1'b1);
                    else
                    begin
                        for (i = 0; i < SLOTS; i++)
                            if (hit < 0 && tbl_dest[i] == '0)
                                hit = i;
                        if (hit >= 0)
                        begin
                            tbl_dest[hit]    = it.dest_addr;
                            tbl_seq[hit]     = it.seq_num;
                            tbl_time[hit]    = it.now_ms;
                            tbl_retries[hit] = '0;
                            tbl_handle[hit]  = it.pkt_handle;
                            push_slot_event(EV_ADDED, hit, 1'b1);
                        end
                        else
                            push_event(EV_FULL, '0, it.dest_addr, it.seq_num, it.pkt_handle,
                                       '0, 1'b1);
                    end
                end
            end
            OP_ACK:
            begin
                // free slots never match, even on sequence zero
                for (i = 0; i < SLOTS; i++)
                    if (hit < 0 && tbl_dest[i] != '0 && tbl_seq[i] == it.seq_num)
                        hit = i;
                if (hit >= 0)
                begin
                    push_slot_event(EV_ACKED, hit, 1'b1);
                    clear_entry(hit);
                end
                else
                    push_event(EV_UNKNOWN, '0, '0, it.seq_num, '0, '0, 1'b1);
            end
            OP_TICK:
            begin
                for (i = 0; i < SLOTS; i++)
                begin
                    if (tbl_dest[i] != '0)
                    begin
                        if (tbl_retries[i] > cur_max_retries)
                        begin
                            push_slot_event(EV_DROPPED, i, 1'b0);
                            clear_entry(i);
                        end
                        else
                        begin
                            age = it.now_ms - tbl_time[i];
                            due = (tbl_time[i] == '0) ||
                                  (it.now_ms > tbl_time[i] && age > 32'(cur_timeout) &&
                                   it.now_ms > 32'(cur_timeout));
                            if (due)
                            begin
                                // linear backoff, wrapping at 32 bits
                                tbl_time[i] = it.now_ms + 32'(tbl_retries[i]) * 32'(cur_backoff);
                                if (tbl_retries[i] != RETRY_TOP)
                                    tbl_retries[i] = tbl_retries[i] + 8'd1;
                                push_slot_event(EV_RESEND, i, 1'b0);
                            end
                        end
                    end
                end
                push_event(EV_DONE, '0, '0, '0, '0, '0, 1'b1);
            end
            default:
                push_event(EV_INVALID, '0, it.dest_addr, it.seq_num, it.pkt_handle, '0, 1'b1);
        endcase
    endfunction

    // result checking against the oldest predicted event
    always @(posedge clk)
    begin : check_results
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_events.size() == 0)
                report_mismatch($sformatf("unexpected result, event %0d", out_data.event_res));
            else
            begin
                want = awaited_events.pop_front();
                compare_field("event_res", out_data.event_res, want.event_res);
                compare_field("slot", out_data.slot, want.slot);
                compare_field("out_dest", out_data.out_dest, want.out_dest);
                compare_field("out_seq", out_data.out_seq, want.out_seq);
                compare_field("out_handle", out_data.out_handle, want.out_handle);
                compare_field("retry_count", out_data.retry_count, want.retry_count);
                compare_field("last", out_data.last, want.last);
            end
            results_seen++;
        end
    end

    function automatic in_item_t make_item(logic [1:0] op, logic [15:0] dest, logic [31:0] seq,
                                           logic [31:0] now, logic [7:0] handle);
        in_item_t it;
        it.opcode     = op;
        it.dest_addr  = dest;
        it.seq_num    = seq;
        it.now_ms     = now;
        it.pkt_handle = handle;
        return it;
    endfunction

    // one input transfer, predicted once accepted
    task automatic send_item(in_item_t item);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 29)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_buffer_events(item);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // stop sending and let every awaited result arrive
    task automatic drain_events();
        @(negedge clk);
        in_valid <= 1'b0;
        while (awaited_events.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(int unsigned tmo, int unsigned retries, int unsigned backoff);
        drain_events();
        write_reg(CFG_TIMEOUT, 16'(tmo));
        write_reg(CFG_MAX_RETRIES, 16'(retries & 8'hff));
        write_reg(CFG_BACKOFF, 16'(backoff & 8'hff));
        cur_timeout     = 16'(tmo);
        cur_max_retries = 8'(retries);
        cur_backoff     = 8'(backoff);
    endtask

    // well-formed traffic mostly, with some noise
    function automatic in_item_t random_item();
        in_item_t    it;
        int unsigned pick;
        int unsigned start;
        int unsigned adv;
        int          k;
        int          j;
        logic        found;
        pick          = $urandom_range(99);
        found         = 1'b0;
        it.dest_addr  = ($urandom_range(1) == 1) ? 16'($urandom_range(8, 1))
                                                 : 16'($urandom_range(65535));
        it.seq_num    = ($urandom_range(1) == 1) ? 32'($urandom_range(3)) : $urandom();
        it.now_ms     = wall_ms;
        it.pkt_handle = 8'($urandom_range(255));
        if (pick < 30)
        begin
            it.opcode = OP_ADD;
            if ($urandom_range(19) == 0)
                it.now_ms = '0;
        end
        else if (pick < 60)
        begin
            it.opcode = OP_ACK;
            // usually acknowledge something that is outstanding
            if ($urandom_range(9) < 7)
            begin
                start = $urandom_range(SLOTS - 1);
                for (k = 0; k < SLOTS; k++)
                begin
                    j = (start + k) % SLOTS;
                    if (!found && tbl_dest[j] != '0)
                    begin
                        it.seq_num = tbl_seq[j];
                        found      = 1'b1;
                    end
                end
            end
        end
        else if (pick < 85)
        begin
            it.opcode = OP_TICK;
            adv = $urandom_range(int'(cur_timeout) / 2 + 200);
            if ($urandom_range(9) == 0)
                adv = adv + int'(cur_timeout) + 1;
            wall_ms   = wall_ms + adv;
            it.now_ms = wall_ms;
        end
        else if (pick < 90)
            it.opcode = OP_SPARE;
        else
        begin
            it.opcode    = 2'($urandom_range(3));
            it.dest_addr = 16'($urandom_range(65535));
            it.seq_num   = $urandom();
            it.now_ms    = $urandom();
        end
        return it;
    endfunction

    // adds, duplicates, zero destination and the undecoded opcode
    task automatic test_add_duplicate_invalid();
        send_item(make_item(OP_ADD, 16'hffff, 32'hffff_ffff, 32'd500, 8'hff));
        send_item(make_item(OP_ADD, 16'h0001, 32'h0000_0000, 32'd0, 8'h00));
        send_item(make_item(OP_ADD, 16'hffff, 32'hffff_ffff, 32'd600, 8'h12));
        send_item(make_item(OP_ADD, 16'h0002, 32'hffff_ffff, 32'd700, 8'h34));
        send_item(make_item(OP_ADD, 16'h0000, 32'h0000_0005, 32'd800, 8'h56));
        send_item(make_item(OP_SPARE, 16'ha5a5, 32'h5a5a_5a5a, 32'h1234_5678, 8'hc3));
    endtask

    // resends on timeout, drops past the retry limit, timestamp wrap
    task automatic test_retry_timeout_drop();
        int k;
        send_item(make_item(OP_TICK, '0, '0, 32'd900, '0));
        for (k = 1; k <= 5; k++)
            send_item(make_item(OP_TICK, '0, '0, 32'(2000 * k), '0));
        send_item(make_item(OP_ADD, 16'h0003, 32'h0000_0007, 32'd100, 8'h5a));
        send_item(make_item(OP_TICK, '0, '0, 32'd12000, '0));
        send_item(make_item(OP_TICK, '0, '0, 32'hffff_fff0, '0));
    endtask

    // acknowledgement hit, miss, and sequence zero against free slots
    task automatic test_ack_lookup();
        send_item(make_item(OP_ACK, '0, 32'h0000_0007, '0, '0));
        send_item(make_item(OP_ACK, '0, 32'h0000_0000, '0, '0));
        send_item(make_item(OP_ACK, 16'hffff, 32'h1234_5678, 32'hffff_ffff, 8'hff));
    endtask

    // fill every slot then try one more
    task automatic test_table_full();
        int k;
        for (k = 0; k <= SLOTS; k++)
            send_item(make_item(OP_ADD, 16'(16'h8000 | k), 32'(100 + k), 32'(20000 + k),
                                8'(k * 37)));
    endtask

    task automatic test_random_traffic(int unsigned tmo, int unsigned retries,
                                       int unsigned backoff, logic no_idling, int count);
        int n;
        set_config(tmo, retries, backoff);
        idle_on = !no_idling;
        for (n = 0; n < count; n++)
            send_item(random_item());
        idle_on = 1'b1;
    endtask

    initial
    begin
        int i;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        idle_on        = 1'b1;
        mismatch_count = 0;
        results_seen   = 0;
        wall_ms        = $urandom();
        cur_timeout     = TIMEOUT_RESET;
        cur_max_retries = MAX_RETRIES_RESET;
        cur_backoff     = BACKOFF_RESET;
        for (i = 0; i < SLOTS; i++)
            clear_entry(i);

        // reset
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_add_duplicate_invalid();
        test_retry_timeout_drop();
        test_ack_lookup();
        test_table_full();
        test_random_traffic(1000, 3, 20, 1'b0, 36);
        test_random_traffic(0, 0, 255, 1'b0, 36);
        test_random_traffic(65535, 255, 0, 1'b1, 36);
        test_random_traffic($urandom_range(65535), $urandom_range(255), $urandom_range(255),
                            1'b0, 36);

        drain_events();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
